@@ rtl/plim_pkg.sv @@
// Shared types and constants for the peak limiter with one-pole release.
// Used by every module of the block; depends on nothing.
package plim_pkg;

  localparam int unsigned SAMPLE_W  = 24;
  localparam int unsigned CEIL_W    = 23;
  localparam int unsigned COEFF_W   = 24;
  localparam int unsigned GAIN_W    = 25;
  localparam int unsigned FRAC_W    = 24;
  localparam int unsigned PROD_W    = 2 * GAIN_W;
  localparam int unsigned DIV_STEPS = 24;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned CHANNELS  = 2;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // register index, taken from the word address
  localparam logic REG_CEILING = 1'b0;
  localparam logic REG_RELEASE = 1'b1;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1) << FRAC_W;
  localparam logic [CEIL_W-1:0] CEIL_RESET = {CEIL_W{1'b1}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
  } out_item_t;

endpackage

@@ rtl/plim_div.sv @@
// Restoring divider, one quotient bit per cycle: floor(ceiling * 2^24 / peak).
// Valid only when peak > ceiling. Depends on plim_pkg.
module plim_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [plim_pkg::CEIL_W-1:0]       ceil_in,
  input  logic [plim_pkg::SAMPLE_W-1:0]     peak_in,
  output logic                              done,
  output logic [plim_pkg::FRAC_W-1:0]       quot
);

  logic [plim_pkg::SAMPLE_W-1:0] rem_r;
  logic [plim_pkg::SAMPLE_W-1:0] rem_nxt;
  logic [plim_pkg::SAMPLE_W:0]   shifted;
  logic                          fits;
  logic [plim_pkg::FRAC_W-1:0]   quot_r;
  logic [plim_pkg::CNT_W-1:0]    cnt_r;
  logic                          busy_r;
  logic                          done_r;

  always_comb begin
    shifted = {rem_r, 1'b0};
    fits    = shifted >= {1'b0, peak_in};
    if (fits) begin
      rem_nxt = plim_pkg::SAMPLE_W'(shifted - {1'b0, peak_in});
    end else begin
      rem_nxt = shifted[plim_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == plim_pkg::CNT_W'(plim_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, ceil_in};
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[plim_pkg::FRAC_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

@@ rtl/plim_mul.sv @@
// Shared unsigned multiplier with a registered product, one result per cycle.
// Depends on plim_pkg.
module plim_mul (
  input  logic                          clk,
  input  logic [plim_pkg::GAIN_W-1:0]   op_a,
  input  logic [plim_pkg::GAIN_W-1:0]   op_b,
  output logic [plim_pkg::PROD_W-1:0]   prod
);

  logic [plim_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

@@ rtl/peak_limiter_release.sv @@
// Stereo peak limiter, instant attack, one-pole release: top level.
// Uses plim_pkg, plim_div and plim_mul.
//
// Usage:
//   in_valid/in_stall carry one stereo frame of signed Q1.23 samples.
//   out_valid/out_stall carry the limited frame, one result per frame.
//   cfg_* is an APB-style port: ceiling at 0x0, release coefficient at 0x4.
//   Write configuration only while no frame is in flight.
// Sequence:
//   A frame whose peak is within the ceiling skips the divide; one above it
//   first runs the 24-step serial divide that forms the target gain, then
//   has its gain cut at once or updated by release. The passes through the
//   one shared multiplier follow (release update, then left, then right).
//   in_stall is high from accept until the result is loaded into the output
//   register, so one frame is processed at a time.
// Reset: gain returns to unity, ceiling to full scale, release to instant,
//   the output register empties.
// Stall: the output register holds its item while out_stall is high; a new
//   frame is accepted only once the waiting result has moved into the register.
module peak_limiter_release (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  plim_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output plim_pkg::out_item_t                 out_data,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [plim_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [plim_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [plim_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_TGT  = 9'b000000010,
    S_DIV  = 9'b000000100,
    S_GA   = 9'b000001000,
    S_GB   = 9'b000010000,
    S_GC   = 9'b000100000,
    S_ML   = 9'b001000000,
    S_MR   = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [plim_pkg::CEIL_W-1:0]    ceil_r;
  logic [plim_pkg::COEFF_W-1:0]   rel_r;
  logic [plim_pkg::GAIN_W-1:0]    gain_r;
  logic [plim_pkg::GAIN_W-1:0]    target_r;
  logic [plim_pkg::SAMPLE_W-1:0]  magl_r, magr_r, peak_r;
  logic                           negl_r, negr_r;
  logic [plim_pkg::PROD_W-1:0]    acc_r;
  logic signed [plim_pkg::SAMPLE_W-1:0] resl_r;
  logic                           out_valid_r;
  plim_pkg::out_item_t            out_data_r;

  logic                           in_acc;
  logic                           out_free;
  logic                           cfg_wr;
  logic [plim_pkg::SAMPLE_W-1:0]  in_magl, in_magr, in_peak;
  logic [plim_pkg::GAIN_W-1:0]    mul_a, mul_b;
  logic [plim_pkg::PROD_W-1:0]    prod;
  logic [plim_pkg::PROD_W:0]      blend_sum;
  logic                           div_start, div_done;
  logic [plim_pkg::FRAC_W-1:0]    div_quot;
  logic [plim_pkg::SAMPLE_W-1:0]  scaled_mag;
  logic signed [plim_pkg::SAMPLE_W-1:0] scaled_out;
  logic                           scaled_neg;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign div_start = (state_r == S_TGT) && (peak_r > {1'b0, ceil_r});

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceil_r <= plim_pkg::CEIL_RESET;
      rel_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        plim_pkg::REG_CEILING: ceil_r <= cfg_pwdata[plim_pkg::CEIL_W-1:0];
        plim_pkg::REG_RELEASE: rel_r  <= cfg_pwdata[plim_pkg::COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      plim_pkg::REG_CEILING: cfg_prdata = plim_pkg::CFG_DATA_W'(ceil_r);
      plim_pkg::REG_RELEASE: cfg_prdata = plim_pkg::CFG_DATA_W'(rel_r);
      default:               cfg_prdata = '0;
    endcase
  end

  // input magnitudes and peak
  always_comb begin
    in_magl = in_data.sample_left[plim_pkg::SAMPLE_W-1]
            ? plim_pkg::SAMPLE_W'(0 - in_data.sample_left)  : in_data.sample_left;
    in_magr = in_data.sample_right[plim_pkg::SAMPLE_W-1]
            ? plim_pkg::SAMPLE_W'(0 - in_data.sample_right) : in_data.sample_right;
    in_peak = in_magl;
    if (plim_pkg::CHANNELS >= 2 && in_magr > in_magl) begin
      in_peak = in_magr;
    end
  end

  // multiplier operand select; MR and OUT share operands so the product holds
  always_comb begin
    mul_a = {1'b0, magr_r};
    mul_b = gain_r;
    case (state_r)
      S_GA: begin
        mul_a = {1'b0, rel_r};
        mul_b = gain_r;
      end
      S_GB: begin
        mul_a = plim_pkg::UNITY_GAIN - {1'b0, rel_r};
        mul_b = target_r;
      end
      S_ML: begin
        mul_a = {1'b0, magl_r};
        mul_b = gain_r;
      end
      default: ;
    endcase
  end

  plim_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  plim_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .ceil_in (ceil_r),
    .peak_in (peak_r),
    .done    (div_done),
    .quot    (div_quot)
  );

  assign blend_sum = {1'b0, acc_r} + {1'b0, prod};

  // scale, truncate, clamp to the ceiling and restore sign
  always_comb begin
    scaled_mag = prod[plim_pkg::FRAC_W +: plim_pkg::SAMPLE_W];
    if (scaled_mag > {1'b0, ceil_r}) begin
      scaled_mag = {1'b0, ceil_r};
    end
    scaled_neg = (state_r == S_MR) ? negl_r : negr_r;
    scaled_out = scaled_neg ? plim_pkg::SAMPLE_W'(0 - scaled_mag) : scaled_mag;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_TGT;
      S_TGT:  state_nxt = div_start ? S_DIV : S_GA;
      S_DIV:  if (div_done) state_nxt = S_GA;
      S_GA:   state_nxt = (target_r < gain_r) ? S_ML : S_GB;
      S_GB:   state_nxt = S_GC;
      S_GC:   state_nxt = S_ML;
      S_ML:   state_nxt = S_MR;
      S_MR:   state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gain_r      <= plim_pkg::UNITY_GAIN;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_GA && target_r < gain_r) begin
        gain_r <= target_r;
      end else if (state_r == S_GC) begin
        gain_r <= blend_sum[plim_pkg::FRAC_W +: plim_pkg::GAIN_W];
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      magl_r <= in_magl;
      magr_r <= in_magr;
      negl_r <= in_data.sample_left[plim_pkg::SAMPLE_W-1];
      negr_r <= in_data.sample_right[plim_pkg::SAMPLE_W-1];
      peak_r <= in_peak;
    end
    if (state_r == S_TGT && !div_start) begin
      target_r <= plim_pkg::UNITY_GAIN;
    end else if (state_r == S_DIV && div_done) begin
      target_r <= {1'b0, div_quot};
    end
    if (state_r == S_GB) begin
      acc_r <= prod;
    end
    if (state_r == S_MR) begin
      resl_r <= scaled_out;
    end
    if (state_r == S_OUT && out_free) begin
      out_data_r.out_left  <= resl_r;
      out_data_r.out_right <= (plim_pkg::CHANNELS >= 2) ? scaled_out : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/plim_chk.sv @@
// Port-level checker for peak_limiter_release, bound to the top level.
// Depends on plim_pkg.
module plim_chk (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                out_valid,
  input  logic                out_stall,
  input  plim_pkg::out_item_t out_data
);

  // hold a stalled item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

  // a frame keeps the block busy after it is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall ##1 in_stall ##1 in_stall ##1 in_stall)
    else $error("block took a new item too soon");

  // a result only follows work in progress
  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in flight");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind peak_limiter_release plim_chk u_plim_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for peak_limiter_release: directed frames, then random frames
// under several ceiling and release settings, each result checked against a local gain model or a known value.
// Depends on rtl/plim_pkg.sv and rtl/peak_limiter_release.sv.
module testbench;

  localparam int STALL_LIMIT = 4000;
  localparam logic [63:0] UNITY64 = 64'(plim_pkg::UNITY_GAIN);
  localparam logic [63:0] WRAP24 = 64'h1000000;

  typedef struct {
    logic                value_is_cfg;
    logic                reg_sel;
    logic [31:0]         value;
    plim_pkg::in_item_t  frame;
    logic                typed;
    plim_pkg::out_item_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  plim_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  plim_pkg::out_item_t out_data;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [plim_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [plim_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [plim_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  // model state and register copies
  logic [plim_pkg::GAIN_W-1:0]  gain_q;
  logic [plim_pkg::CEIL_W-1:0]  ceiling_q;
  logic [plim_pkg::COEFF_W-1:0] release_q;

  plim_pkg::out_item_t expected_out[$];
  plan_row_t directed_plan[$];
  int idle_pct = 36;
  int stall_pct = 36;
  int fault_count = 0;
  int frames_sent = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int quiet_cycles = 0;
  int item_count;

  peak_limiter_release u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // Gain model: instant attack, one-pole release, truncating multiply, clamp to ceiling.
  function automatic plim_pkg::out_item_t limit_frame(plim_pkg::in_item_t frame);
    logic [23:0] raw [2];
    logic [23:0] lim [2];
    logic [63:0] mag [2];
    logic        neg [2];
    logic [63:0] peak;
    logic [63:0] target;
    logic [63:0] level;
    plim_pkg::out_item_t res;
    raw[0] = frame.sample_left;
    raw[1] = frame.sample_right;
    peak = 64'd0;
    for (int c = 0; c < 2; c++) begin
      neg[c] = raw[c][23];
      mag[c] = neg[c] ? WRAP24 - 64'(raw[c]) : 64'(raw[c]);
      if (c < plim_pkg::CHANNELS && mag[c] > peak) peak = mag[c];
    end
    if (peak > 64'(ceiling_q)) target = (64'(ceiling_q) << 24) / peak;
    else target = UNITY64;
    if (target < 64'(gain_q)) begin
      gain_q = plim_pkg::GAIN_W'(target);
    end else begin
      gain_q = plim_pkg::GAIN_W'((64'(release_q) * 64'(gain_q)
                                  + (UNITY64 - 64'(release_q)) * target) >> 24);
    end
    for (int c = 0; c < 2; c++) begin
      if (c >= plim_pkg::CHANNELS) begin
        lim[c] = 24'd0;
      end else begin
        level = (mag[c] * 64'(gain_q)) >> 24;
        if (level > 64'(ceiling_q)) level = 64'(ceiling_q);
        lim[c] = neg[c] ? 24'(WRAP24 - level) : 24'(level);
      end
    end
    res.out_left = lim[0];
    res.out_right = lim[1];
    return res;
  endfunction

  function automatic plan_row_t frame_row(int l, int r);
    plan_row_t row;
    row.value_is_cfg = 1'b0;
    row.reg_sel = plim_pkg::REG_CEILING;
    row.value = '0;
    row.frame.sample_left = 24'(l);
    row.frame.sample_right = 24'(r);
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic plan_row_t known_row(int l, int r, int el, int er);
    plan_row_t row;
    row = frame_row(l, r);
    row.typed = 1'b1;
    row.want.out_left = 24'(el);
    row.want.out_right = 24'(er);
    return row;
  endfunction

  function automatic plan_row_t reg_row(logic sel, int unsigned v);
    plan_row_t row;
    row = frame_row(0, 0);
    row.value_is_cfg = 1'b1;
    row.reg_sel = sel;
    row.value = 32'(v);
    return row;
  endfunction

  // Mix of full-range noise, extremes, quiet material and levels near the ceiling.
  function automatic logic [23:0] pick_sample();
    logic [63:0] mag;
    logic [23:0] v;
    mag = 64'd0;
    v = 24'd0;
    case ($urandom_range(9))
      0, 1, 2: v = 24'($urandom);
      3: begin
        case ($urandom_range(4))
          0: v = 24'h000000;
          1: v = 24'h000001;
          2: v = 24'hFFFFFF;
          3: v = 24'h7FFFFF;
          default: v = 24'h800000;
        endcase
      end
      4, 5, 6: mag = 64'($urandom_range(4095));
      default: begin
        mag = 64'(ceiling_q) + 64'($urandom_range(64));
        mag = (mag > 64'd32) ? mag - 64'd32 : 64'd0;
        if (mag > 64'h800000) mag = 64'h800000;
      end
    endcase
    if (mag != 64'd0) v = $urandom_range(1) ? 24'(WRAP24 - mag) : 24'(mag);
    return v;
  endfunction

  task automatic note_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("MISMATCH %0t: %s", $realtime, msg);
  endtask

  task automatic check_result(plim_pkg::out_item_t got);
    plim_pkg::out_item_t want;
    if (expected_out.size() == 0) begin
      note_fault($sformatf("result with nothing pending: L=%0d R=%0d",
                           got.out_left, got.out_right));
    end else begin
      want = expected_out.pop_front();
      results_checked++;
      if (got.out_left !== want.out_left)
        note_fault($sformatf("out_left exp %0d got %0d", want.out_left, got.out_left));
      if (got.out_right !== want.out_right)
        note_fault($sformatf("out_right exp %0d got %0d", want.out_right, got.out_right));
    end
  endtask

  // Called at a falling edge; returns at a falling edge with in_valid still high.
  task automatic send_frame(plim_pkg::in_item_t frame, logic typed,
                            plim_pkg::out_item_t want);
    plim_pkg::out_item_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= frame;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = limit_frame(frame);
    expected_out.push_back(typed ? want : predicted);
    frames_sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold until every pending result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_out.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic sel, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= plim_pkg::CFG_ADDR_W'({sel, 2'b00});
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (sel == plim_pkg::REG_CEILING) ceiling_q = value[plim_pkg::CEIL_W-1:0];
    else release_q = value[plim_pkg::COEFF_W-1:0];
    cfg_writes++;
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results pending",
               quiet_cycles, expected_out.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    gain_q = plim_pkg::UNITY_GAIN;
    ceiling_q = plim_pkg::CEIL_RESET;
    release_q = '0;

    // reset settings: full-scale ceiling, instant release
    directed_plan.push_back(known_row(0, 0, 0, 0));
    directed_plan.push_back(known_row(1, -1, 1, -1));
    directed_plan.push_back(known_row(8388607, 8388607, 8388607, 8388607));
    directed_plan.push_back(frame_row(-8388608, 0));
    directed_plan.push_back(frame_row(0, -8388608));
    directed_plan.push_back(frame_row(8388607, -8388608));
    directed_plan.push_back(frame_row(100, -100));
    // half-scale ceiling, slowest release
    directed_plan.push_back(reg_row(plim_pkg::REG_CEILING, 4194304));
    directed_plan.push_back(reg_row(plim_pkg::REG_RELEASE, 16777215));
    directed_plan.push_back(frame_row(8388607, 0));
    directed_plan.push_back(frame_row(1000, 1000));
    directed_plan.push_back(frame_row(-8388608, 8388607));
    directed_plan.push_back(frame_row(4194304, -4194304));
    directed_plan.push_back(frame_row(4194305, 0));
    // zero ceiling silences everything
    directed_plan.push_back(reg_row(plim_pkg::REG_CEILING, 0));
    directed_plan.push_back(reg_row(plim_pkg::REG_RELEASE, 0));
    directed_plan.push_back(known_row(0, 0, 0, 0));
    directed_plan.push_back(known_row(5, -5, 0, 0));
    directed_plan.push_back(known_row(-8388608, 8388607, 0, 0));
    // tiny ceiling, mid release
    directed_plan.push_back(reg_row(plim_pkg::REG_CEILING, 1));
    directed_plan.push_back(reg_row(plim_pkg::REG_RELEASE, 8388608));
    directed_plan.push_back(frame_row(1, -1));
    directed_plan.push_back(frame_row(2, 0));
    directed_plan.push_back(frame_row(8388607, -8388608));
    directed_plan.push_back(frame_row(0, 0));
    directed_plan.push_back(reg_row(plim_pkg::REG_CEILING, 8388607));
    directed_plan.push_back(reg_row(plim_pkg::REG_RELEASE, 16777215));
    directed_plan.push_back(frame_row(3, -3));
    directed_plan.push_back(frame_row(8388607, 8388607));

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].value_is_cfg) begin
        drain();
        write_reg(directed_plan[i].reg_sel, directed_plan[i].value);
      end else begin
        send_frame(directed_plan[i].frame, directed_plan[i].typed, directed_plan[i].want);
      end
    end

    for (int phase = 0; phase < 5; phase++) begin
      drain();
      case (phase)
        0: begin
          write_reg(plim_pkg::REG_CEILING, $urandom_range(8388607));
          write_reg(plim_pkg::REG_RELEASE, $urandom_range(16777215));
        end
        1: begin
          write_reg(plim_pkg::REG_CEILING, 8388607);
          write_reg(plim_pkg::REG_RELEASE, 16777215);
        end
        2: begin
          write_reg(plim_pkg::REG_CEILING, 0);
          write_reg(plim_pkg::REG_RELEASE, $urandom_range(16777215));
        end
        3: begin
          write_reg(plim_pkg::REG_CEILING, $urandom_range(255, 1));
          write_reg(plim_pkg::REG_RELEASE, 0);
        end
        default: begin
          write_reg(plim_pkg::REG_CEILING, $urandom_range(8388607, 1048576));
          write_reg(plim_pkg::REG_RELEASE, $urandom_range(16777215, 16700000));
        end
      endcase
      // one phase runs back to back on both sides
      idle_pct = (phase == 1) ? 0 : 36;
      stall_pct = (phase == 1) ? 0 : 36;
      item_count = (phase == 2) ? 40 : 190;
      for (int n = 0; n < item_count; n++) begin
        send_frame(plim_pkg::in_item_t'({pick_sample(), pick_sample()}), 1'b0, '0);
        if ($urandom_range(63) == 0) drain();
      end
    end

    drain();
    repeat (40) @(negedge clk);
    fault_count += expected_out.size();
    $display("%0d frames through %0d register writes, ceilings from zero to full scale,",
             frames_sent, cfg_writes);
    $display("release from instant to slowest; %0d results compared", results_checked);
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
